/* rtl/aaes_pkg.sv */
// Shared types and constants for the accelerometer activity epoch summary block.
package aaes_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int ACTIVITY_W   = 12;
    localparam int BIN_NUMBER_W = 10;
    localparam int BIN_COUNT_W  = 16;
    localparam int EPOCH_W      = 12;
    localparam int AXES         = 3;

    localparam logic [EPOCH_W-1:0]     EPOCH_RESET = 12'd2400;
    localparam logic [BIN_COUNT_W-1:0] BIN_MAX     = 16'hFFFF;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_DRAIN  = 2'd1,
        OP_FINAL  = 2'd2
    } op_t;

    typedef struct packed {
        logic                command;
        logic [SAMPLE_W-1:0] x_sample;
        logic [SAMPLE_W-1:0] y_sample;
        logic [SAMPLE_W-1:0] z_sample;
    } in_item_t;

    typedef struct packed {
        logic [ACTIVITY_W-1:0]   activity;
        logic [BIN_NUMBER_W-1:0] bin_number;
        logic [BIN_COUNT_W-1:0]  bin_count;
        logic                    bin_valid;
        logic                    last;
    } out_item_t;

endpackage

/* rtl/accel_activity_epoch_summary_top.sv */
// Top level of the accelerometer activity epoch summary block.
// The block takes one request per clock cycle and sustains that rate while the output is not
// stalled: each request is accepted into a single processing stage and its result lands in
// the output register when that stage advances, while the next request is already being
// taken. The rate is set by the bin memory and the window store, both read at acceptance
// with registered read data and written back as the request leaves the processing stage;
// a one-entry bypass carries a write-back to the request immediately behind it. Bins are
// not swept after reset: the bin under the pointer is tracked as fresh and reads as zero,
// so the block is ready from the first cycle. A new epoch_length is picked up at the next
// epoch boundary.
module accel_activity_epoch_summary_top
    import aaes_pkg::*;
#(
    parameter int BIN_COUNT  = 960,
    parameter int WINDOW_LEN = 39
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_data,
    input  logic                cfg_we,
    input  logic [EPOCH_W-1:0]  cfg_wdata
);

    localparam int HEAD_W  = $clog2(WINDOW_LEN);
    localparam int BIN_W   = $clog2(BIN_COUNT);
    localparam int SUM_W   = $clog2(WINDOW_LEN * ((1 << SAMPLE_W) - 1) + 1);
    localparam int SHIFT   = SUM_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_FULL);
    localparam logic [HEAD_W-1:0]  HEAD_LAST = HEAD_W'(WINDOW_LEN - 1);
    localparam logic [BIN_W-1:0]   BIN_LAST  = BIN_W'(BIN_COUNT - 1);
    localparam logic [SUM_W-1:0]   WIN_LEN_S = SUM_W'(WINDOW_LEN);

    // Memories
    logic [BIN_COUNT_W-1:0]                 bin_mem [BIN_COUNT];
    logic [AXES-1:0][SAMPLE_W-1:0]          win_mem [WINDOW_LEN];
    logic [BIN_COUNT_W-1:0]                 bin_rdata_reg;
    logic [AXES-1:0][SAMPLE_W-1:0]          win_rdata_reg;

    // Architectural control state
    logic [EPOCH_W-1:0] epoch_length_reg;
    logic [EPOCH_W-1:0] countdown_reg, countdown_next;
    logic [BIN_W-1:0]   bin_ptr_reg, bin_ptr_next;
    logic [BIN_W-1:0]   drain_ptr_reg, drain_ptr_next;
    logic [HEAD_W-1:0]  head_reg, head_next;
    logic               full_reg, full_next;
    logic               fresh_reg, fresh_next;
    logic [AXES-1:0][SUM_W-1:0] sums_reg, sums_next;

    // Processing stage
    logic                          s1_valid_reg;
    op_t                           s1_op_reg;
    logic [AXES-1:0][SAMPLE_W-1:0] s1_samples_reg;
    logic [HEAD_W-1:0]             s1_head_reg;
    logic                          s1_full_reg;
    logic [BIN_W-1:0]              s1_bin_addr_reg;
    logic                          s1_fresh_reg;
    logic                          s1_byp_hit_reg;
    logic [BIN_COUNT_W-1:0]        s1_byp_data_reg;

    // Output register
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic       in_fire;
    logic       s1_adv;
    op_t        op_in;
    logic [BIN_W-1:0] bin_raddr;
    logic       byp_hit_next;

    logic                          bin_we;
    logic [BIN_W-1:0]              bin_waddr;
    logic [BIN_COUNT_W-1:0]        bin_wdata;
    logic                          win_we;
    logic [BIN_COUNT_W-1:0]        bin_value;
    logic [AXES-1:0][SAMPLE_W-1:0] oldest;
    logic [AXES-1:0][SUM_W-1:0]    scaled;
    logic [AXES-1:0][SUM_W-1:0]    diff;
    logic [AXES-1:0][PROD_W-1:0]   prod;
    logic [AXES-1:0][SAMPLE_W-1:0] deviation;
    logic [ACTIVITY_W-1:0]         activity;
    logic [BIN_COUNT_W:0]          bin_total;
    logic [BIN_COUNT_W-1:0]        bin_sat;
    out_item_t                     result;
    logic                          result_we;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Decode and architectural state update at acceptance.
    always_comb
    begin
        if (in_data.command == CMD_DRAIN)
        begin
            op_in = (drain_ptr_reg < bin_ptr_reg) ? OP_DRAIN : OP_FINAL;
        end
        else
        begin
            op_in = OP_SAMPLE;
        end
        bin_raddr = (op_in == OP_DRAIN) ? drain_ptr_reg : bin_ptr_reg;

        countdown_next = countdown_reg;
        bin_ptr_next   = bin_ptr_reg;
        drain_ptr_next = drain_ptr_reg;
        head_next      = head_reg;
        full_next      = full_reg;
        fresh_next     = fresh_reg;

        if (in_fire)
        begin
            unique case (op_in)
                OP_SAMPLE:
                begin
                    if (head_reg == HEAD_LAST)
                    begin
                        head_next = '0;
                        full_next = 1'b1;
                    end
                    else
                    begin
                        head_next = head_reg + 1'b1;
                    end
                    // A bin entered at an epoch boundary is fresh and reads as zero
                    // until its first sample is written.
                    if (countdown_reg == '0)
                    begin
                        bin_ptr_next   = (bin_ptr_reg == BIN_LAST) ? '0 : bin_ptr_reg + 1'b1;
                        fresh_next     = 1'b1;
                        countdown_next = epoch_length_reg;
                    end
                    else
                    begin
                        fresh_next     = 1'b0;
                        countdown_next = countdown_reg - 1'b1;
                    end
                end
                OP_DRAIN:
                begin
                    drain_ptr_next = drain_ptr_reg + 1'b1;
                end
                OP_FINAL:
                begin
                    bin_ptr_next   = '0;
                    drain_ptr_next = '0;
                    fresh_next     = 1'b0;
                end
                default:
                begin
                    bin_ptr_next = bin_ptr_reg;
                end
            endcase
        end
    end

    // The request behind a write-back reads the memory in the same edge, so it takes
    // the written value from the bypass instead.
    assign byp_hit_next = bin_we && (bin_waddr == bin_raddr);

    // Processing stage datapath.
    always_comb
    begin
        if (s1_fresh_reg)
        begin
            bin_value = '0;
        end
        else if (s1_byp_hit_reg)
        begin
            bin_value = s1_byp_data_reg;
        end
        else
        begin
            bin_value = bin_rdata_reg;
        end

        for (int a = 0; a < AXES; a++)
        begin
            oldest[a]    = s1_full_reg ? win_rdata_reg[a] : '0;
            scaled[a]    = SUM_W'(s1_samples_reg[a]) * WIN_LEN_S;
            diff[a]      = (scaled[a] >= sums_reg[a]) ? scaled[a] - sums_reg[a]
                                                      : sums_reg[a] - scaled[a];
            // Exact division by the window length through a rounded-up reciprocal.
            prod[a]      = PROD_W'(diff[a]) * PROD_W'(RECIP);
            deviation[a] = prod[a][SHIFT +: SAMPLE_W];
            sums_next[a] = sums_reg[a] - SUM_W'(oldest[a]) + SUM_W'(s1_samples_reg[a]);
        end

        activity  = ACTIVITY_W'(deviation[0]) + ACTIVITY_W'(deviation[1])
                  + ACTIVITY_W'(deviation[2]);
        bin_total = {1'b0, bin_value} + (BIN_COUNT_W + 1)'(activity);
        bin_sat   = bin_total[BIN_COUNT_W] ? BIN_MAX : bin_total[BIN_COUNT_W-1:0];

        result    = '0;
        result_we = 1'b0;
        bin_waddr = s1_bin_addr_reg;
        bin_wdata = bin_sat;
        unique case (s1_op_reg)
            OP_SAMPLE:
            begin
                result.activity   = activity;
                result.bin_number = BIN_NUMBER_W'(s1_bin_addr_reg);
                result.bin_count  = bin_sat;
                result_we         = 1'b1;
            end
            OP_DRAIN:
            begin
                result.bin_number = BIN_NUMBER_W'(s1_bin_addr_reg);
                result.bin_count  = bin_value;
                result.bin_valid  = 1'b1;
            end
            OP_FINAL:
            begin
                // The current bin moves to slot zero; its old slot is never read again
                // before the pointer re-enters it as a fresh bin.
                result.bin_count = bin_value;
                result.last      = 1'b1;
                result_we        = 1'b1;
                bin_waddr        = '0;
                bin_wdata        = bin_value;
            end
            default:
            begin
                result_we = 1'b0;
            end
        endcase

        bin_we = s1_adv && result_we;
        win_we = s1_adv && (s1_op_reg == OP_SAMPLE);
    end

    always_ff @(posedge clk)
    begin
        if (bin_we)
        begin
            bin_mem[bin_waddr] <= bin_wdata;
        end
        if (in_fire)
        begin
            bin_rdata_reg <= bin_mem[bin_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[s1_head_reg] <= s1_samples_reg;
        end
        if (in_fire)
        begin
            win_rdata_reg <= win_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg         <= op_in;
            s1_samples_reg    <= {in_data.z_sample, in_data.y_sample, in_data.x_sample};
            s1_head_reg       <= head_reg;
            s1_full_reg       <= full_reg;
            s1_bin_addr_reg   <= bin_raddr;
            s1_fresh_reg      <= fresh_reg && (op_in != OP_DRAIN);
            s1_byp_hit_reg    <= byp_hit_next;
            s1_byp_data_reg   <= bin_wdata;
        end
        if (s1_adv)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_length_reg <= EPOCH_RESET;
            countdown_reg    <= EPOCH_RESET;
            bin_ptr_reg      <= '0;
            drain_ptr_reg    <= '0;
            head_reg         <= '0;
            full_reg         <= 1'b0;
            fresh_reg        <= 1'b1;
            sums_reg         <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                epoch_length_reg <= cfg_wdata;
            end
            countdown_reg <= countdown_next;
            bin_ptr_reg   <= bin_ptr_next;
            drain_ptr_reg <= drain_ptr_next;
            head_reg      <= head_next;
            full_reg      <= full_next;
            fresh_reg     <= fresh_next;
            if (win_we)
            begin
                sums_reg <= sums_next;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
